// ----- src/linear_blend_skin_position_assert.svh -----
// Assertion macros shared by the skinning block.
// Expects clk and arst_n in the scope of use.
`ifndef LINEAR_BLEND_SKIN_POSITION_ASSERT_SVH
`define LINEAR_BLEND_SKIN_POSITION_ASSERT_SVH

// same-cycle implication
`define LBS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbs check failed");

// next-cycle implication
`define LBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbs check failed");

`endif

// ----- src/lbs_pkg.sv -----
// Constants and types for the linear blend skinning block.
// No dependencies.
package lbs_pkg;
	localparam int BONES      = 64;
	localparam int INFLUENCES = 4;
	// influences that carry bits in the input word
	localparam int NINF       = (INFLUENCES < 4) ? INFLUENCES : 4;
	localparam int BONE_W     = 6;
	localparam int WEIGHT_W   = 16;
	localparam int ROWS       = 3;
	localparam int ROW_W      = 128;

	localparam logic [1:0] ROW_X    = 2'd0;
	localparam logic [1:0] ROW_Y    = 2'd1;
	localparam logic [1:0] ROW_Z    = 2'd2;
	// load row that the block ignores
	localparam logic [1:0] ROW_NONE = 2'd3;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_SKIN = 1'b1;

	typedef logic signed [31:0] q16_t;
	typedef q16_t vec3_t [ROWS];
endpackage

// ----- src/lbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- src/linear_blend_skin_position.sv -----
// Top level of the linear blend skinning block: palette RAMs and pipeline.
// Depends on lbs_pkg, lbs_ram and linear_blend_skin_position_assert.svh.
//
// Use: one input stream s_* carries load words (tuser 0) that write one
// 3x4 skin matrix row of a bone, and vertex words (tuser 1) that bring a
// Q16.16 bind position, four bone indices and four Q1.15 weights. Every
// vertex word gives one result word on m_*: the skinned position, and
// tuser set when all weights were zero and the bind position came back.
// Load words give no result.
// Throughput: one word per cycle while m_tready does not stall the output,
// set by the five register stages (palette read, 36 coefficient
// multipliers, row rounding, weight multipliers, sum and saturate) each
// taking a new word every cycle.
// Palette words are undefined until written; no clearing runs after reset.
// Reset empties the pipeline. When m_tready is low the output word holds
// and each stage keeps taking words until it is full (bubbles collapse),
// so nothing is lost or repeated.
`include "linear_blend_skin_position_assert.svh"
module linear_blend_skin_position
	import lbs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x, pos_y, pos_z, bone_set, weight_set, palette_bone, palette_row,
	// coef_x, coef_y, coef_z, coef_t
	input  logic [319:0] s_tdata,
	// action
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x, out_y, out_z
	output logic [95:0]  m_tdata,
	// passed_bind
	output logic [0:0]   m_tuser
);
	// input field unpacking
	vec3_t                pos_in;
	logic [23:0]          bone_set;
	logic [63:0]          weight_set;
	logic [BONE_W-1:0]    pal_bone;
	logic [1:0]           pal_row;
	logic [ROW_W-1:0]     pal_data;

	assign pos_in[0]  = s_tdata[31:0];
	assign pos_in[1]  = s_tdata[63:32];
	assign pos_in[2]  = s_tdata[95:64];
	assign bone_set   = s_tdata[119:96];
	assign weight_set = s_tdata[183:120];
	assign pal_bone   = s_tdata[189:184];
	assign pal_row    = s_tdata[191:190];
	assign pal_data   = s_tdata[319:192];   // coef_x lowest, coef_t highest

	// stage valids and ready chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	assign rdy_s5   = !v_s5 || m_tready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	logic acc_in, acc_skin, acc_load;
	assign acc_in   = s_tvalid && s_tready;
	assign acc_skin = acc_in && (s_tuser[0] == ACT_SKIN);
	assign acc_load = acc_in && (s_tuser[0] == ACT_LOAD);

	// a load to a missing bone or to row three is dropped
	logic load_ok;
	assign load_ok = (int'(pal_bone) < BONES) && (pal_row != ROW_NONE);

	// palette: one RAM copy per influence and row, so all reads of a vertex
	// happen in the same cycle; a load writes every copy of its row
	logic [ROW_W-1:0] rd_s1 [NINF][ROWS];

	for (genvar gi = 0; gi < NINF; gi++) begin : g_inf
		for (genvar gr = 0; gr < ROWS; gr++) begin : g_row
			lbs_ram #(
				.WIDTH(ROW_W),
				.DEPTH(BONES)
			) u_pal (
				.clk   (clk),
				.we    (acc_load && load_ok && (pal_row == 2'(gr))),
				.waddr (pal_bone[$clog2(BONES)-1:0]),
				.wdata (pal_data),
				.re    (rdy_s1),
				.raddr (bone_set[gi*BONE_W +: $clog2(BONES)]),
				.rdata (rd_s1[gi][gr])
			);
		end
	end

	// stage 1: weights, with influences naming a missing bone zeroed
	vec3_t                pos_s1;
	logic [WEIGHT_W-1:0]  w_s1 [NINF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= acc_skin;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			pos_s1 <= pos_in;
			for (int i = 0; i < NINF; i++) begin
				if (int'(bone_set[i*BONE_W +: BONE_W]) < BONES) begin
					w_s1[i] <= weight_set[i*WEIGHT_W +: WEIGHT_W];
				end else begin
					w_s1[i] <= '0;
				end
			end
		end
	end

	// stage 2: coefficient products, exact Q32.32
	logic signed [63:0]   prod_s2 [NINF][ROWS][3];
	q16_t                 tr_s2   [NINF][ROWS];
	vec3_t                pos_s2;
	logic [WEIGHT_W-1:0]  w_s2 [NINF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			pos_s2 <= pos_s1;
			w_s2   <= w_s1;
			for (int i = 0; i < NINF; i++) begin
				for (int r = 0; r < ROWS; r++) begin
					for (int k = 0; k < 3; k++) begin
						prod_s2[i][r][k] <= $signed(rd_s1[i][r][k*32 +: 32]) * pos_s1[k];
					end
					tr_s2[i][r] <= $signed(rd_s1[i][r][96 +: 32]);
				end
			end
		end
	end

	// stage 3: row sums rounded half up to Q16.16 and saturated
	q16_t crd_c [NINF][ROWS];

	always_comb begin
		logic signed [65:0] acc;
		logic signed [49:0] rsh;
		for (int i = 0; i < NINF; i++) begin
			for (int r = 0; r < ROWS; r++) begin
				acc = 66'(prod_s2[i][r][0]) + 66'(prod_s2[i][r][1])
					+ 66'(prod_s2[i][r][2])
					+ $signed({{18{tr_s2[i][r][31]}}, tr_s2[i][r], 16'h0000})
					+ 66'sd32768;
				rsh = acc[65:16];
				if (rsh[49:31] != {19{rsh[49]}}) begin
					crd_c[i][r] = rsh[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				end else begin
					crd_c[i][r] = rsh[31:0];
				end
			end
		end
	end

	q16_t                 crd_s3 [NINF][ROWS];
	vec3_t                pos_s3;
	logic [WEIGHT_W-1:0]  w_s3 [NINF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			crd_s3 <= crd_c;
			pos_s3 <= pos_s2;
			w_s3   <= w_s2;
		end
	end

	// stage 4: weight each bone coordinate
	logic signed [48:0]   wp_s4 [NINF][ROWS];
	vec3_t                pos_s4;
	logic                 any_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic any;
		if (rdy_s4) begin
			any = 1'b0;
			for (int i = 0; i < NINF; i++) begin
				any = any || (w_s3[i] != '0);
				for (int r = 0; r < ROWS; r++) begin
					wp_s4[i][r] <= crd_s3[i][r] * $signed({1'b0, w_s3[i]});
				end
			end
			any_s4 <= any;
			pos_s4 <= pos_s3;
		end
	end

	// stage 5: sum, round half up from Q.31 to Q16.16, saturate
	vec3_t sum_c;

	always_comb begin
		logic signed [51:0] acc;
		logic signed [36:0] rsh;
		for (int r = 0; r < ROWS; r++) begin
			acc = 52'sd16384;
			for (int i = 0; i < NINF; i++) begin
				acc = acc + 52'(wp_s4[i][r]);
			end
			rsh = acc[51:15];
			if (rsh[36:31] != {6{rsh[36]}}) begin
				sum_c[r] = rsh[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end else begin
				sum_c[r] = rsh[31:0];
			end
		end
	end

	vec3_t out_s5;
	logic  bind_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			if (any_s4) begin
				out_s5 <= sum_c;
			end else begin
				out_s5 <= pos_s4;   // no influence: bind position
			end
			bind_s5 <= !any_s4;
		end
	end

	assign m_tvalid   = v_s5;
	assign m_tdata    = {out_s5[2], out_s5[1], out_s5[0]};
	assign m_tuser[0] = bind_s5;

	// checks
	`LBS_ASSERT_NEXT(a_skin_enters, acc_skin, v_s1)
	`LBS_ASSERT_NEXT(a_load_no_result, acc_load && rdy_s1, !v_s1)
	`LBS_ASSERT_NEXT(a_stage4_holds, v_s4 && !rdy_s5, v_s4)
endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for linear_blend_skin_position: directed and random
// palette loads and vertex words, with a scoreboard that predicts every result.
// Depends on lbs_pkg and the block's RTL.
module tb_top;
	import lbs_pkg::*;

	typedef struct {
		logic       action;
		q16_t       pos [3];
		logic [23:0] bone_set;
		logic [63:0] weight_set;
		logic [5:0] pal_bone;
		logic [1:0] pal_row;
		q16_t       coef [4];
	} skin_word_t;

	typedef struct {
		q16_t x, y, z;
		logic flag;
	} skinned_t;

	// Skinning scoreboard: keeps its own palette and the queue of expected vertices
	class skin_scoreboard;
		q16_t       palette [BONES*12];
		bit         row_set [BONES][3];
		skinned_t   expected_q [$];
		int         errors;

		function new();
			errors = 0;
			foreach (row_set[b, r]) row_set[b][r] = 0;
		endfunction

		function bit bone_ready(int b);
			return row_set[b][0] && row_set[b][1] && row_set[b][2];
		endfunction

		function q16_t sat32(logic signed [127:0] v);
			if (v > 128'sd2147483647) return 32'sh7FFFFFFF;
			if (v < -128'sd2147483648) return 32'sh80000000;
			return v[31:0];
		endfunction

		// one matrix row of bone b applied to (x, y, z, 1), rounded half up
		function q16_t row_dot(int b, int r, q16_t x, q16_t y, q16_t z);
			logic signed [127:0] acc;
			int base;
			base = (b * 3 + r) * 4;
			acc = palette[base] * x;
			acc = acc + palette[base+1] * y;
			acc = acc + palette[base+2] * z;
			acc = acc + (128'(palette[base+3]) <<< 16) + 128'sd32768;
			return sat32(acc >>> 16);
		endfunction

		function void note(skin_word_t w);
			logic signed [127:0] sum [3];
			logic signed [16:0] wt;
			skinned_t e;
			bit any;
			int b, base;
			if (w.action == ACT_LOAD) begin
				if (w.pal_row == ROW_NONE) return;
				base = (int'(w.pal_bone) * 3 + int'(w.pal_row)) * 4;
				for (int k = 0; k < 4; k++) palette[base+k] = w.coef[k];
				row_set[w.pal_bone][w.pal_row] = 1;
				return;
			end
			any = 0;
			for (int r = 0; r < 3; r++) sum[r] = '0;
			for (int i = 0; i < NINF; i++) begin
				b = w.bone_set[6*i +: 6];
				wt = {1'b0, w.weight_set[16*i +: 16]};
				if (wt == 0 || b >= BONES) continue;
				any = 1;
				for (int r = 0; r < 3; r++)
					sum[r] = sum[r] + row_dot(b, r, w.pos[0], w.pos[1], w.pos[2]) * wt;
			end
			if (!any) begin
				e.x = w.pos[0]; e.y = w.pos[1]; e.z = w.pos[2]; e.flag = 1;
			end else begin
				e.x = sat32((sum[0] + 128'sd16384) >>> 15);
				e.y = sat32((sum[1] + 128'sd16384) >>> 15);
				e.z = sat32((sum[2] + 128'sd16384) >>> 15);
				e.flag = 0;
			end
			expected_q = {expected_q, e};
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check(q16_t x, q16_t y, q16_t z, logic flag);
			skinned_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected word %h %h %h %b", x, y, z, flag));
				return;
			end
			e = expected_q.pop_front();
			if (x !== e.x) report($sformatf("out_x %h, want %h", x, e.x));
			if (y !== e.y) report($sformatf("out_y %h, want %h", y, e.y));
			if (z !== e.z) report($sformatf("out_z %h, want %h", z, e.z));
			if (flag !== e.flag) report($sformatf("passed_bind %b, want %b", flag, e.flag));
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [319:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic [0:0]   m_tuser;

	skin_scoreboard sb;
	bit idle_on;       // random idling enabled on both sides
	int hold_cycles;   // long receiver hold-off requested by the sender

	linear_blend_skin_position uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function int gap_len();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	// receiver: random back-pressure plus the long hold-off
	initial begin
		int stall;
		m_tready = 0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
				stall = gap_len();
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check(m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0]);

	// drive one word and wait for its handshake; gaps go in front of it
	task send(skin_word_t w);
		int g;
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			s_tvalid <= 0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1;
		s_tuser  <= w.action;
		s_tdata  <= {w.coef[3], w.coef[2], w.coef[1], w.coef[0], w.pal_row, w.pal_bone,
			w.weight_set, w.bone_set, w.pos[2], w.pos[1], w.pos[0]};
		forever begin
			@(posedge clk);
			if (s_tready) break;
		end
		sb.note(w);
	endtask

	function q16_t rand_q16();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2, 3: return $urandom;
			default: return $signed($urandom_range(0, 262143)) - 131072;
		endcase
	endfunction

	function skin_word_t row_load(int b, logic [1:0] r);
		skin_word_t w;
		w.action = ACT_LOAD;
		w.pal_bone = 6'(b);
		w.pal_row = r;
		for (int k = 0; k < 4; k++) w.coef[k] = rand_q16();
		// filler fields still toggle
		w.bone_set = 24'($urandom);
		w.weight_set = {$urandom, $urandom};
		for (int k = 0; k < 3; k++) w.pos[k] = $urandom;
		return w;
	endfunction

	function skin_word_t vertex(bit allow_weights);
		skin_word_t w;
		int ready [$];
		int b;
		for (int i = 0; i < BONES; i++) if (sb.bone_ready(i)) ready = {ready, i};
		w = row_load(0, ROW_X);
		w.action = ACT_SKIN;
		w.pal_bone = 6'($urandom);
		w.pal_row = 2'($urandom);
		for (int k = 0; k < 3; k++) w.pos[k] = rand_q16();
		for (int i = 0; i < 4; i++) begin
			if (!allow_weights || ready.size() == 0 || $urandom_range(0, 4) == 0) begin
				w.bone_set[6*i +: 6] = 6'($urandom);
				w.weight_set[16*i +: 16] = '0;
			end else begin
				b = ready[$urandom_range(0, ready.size() - 1)];
				w.bone_set[6*i +: 6] = 6'(b);
				case ($urandom_range(0, 7))
					0: w.weight_set[16*i +: 16] = 16'hFFFF;
					1: w.weight_set[16*i +: 16] = 16'h8000;
					2: w.weight_set[16*i +: 16] = 16'h0001;
					default: w.weight_set[16*i +: 16] = 16'($urandom_range(1, 65535));
				endcase
			end
		end
		return w;
	endfunction

	initial begin
		skin_word_t w;
		sb = new();
		idle_on = 0;
		hold_cycles = 0;
		s_tvalid = 0;
		s_tuser = 0;
		s_tdata = '0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: bind pass-through before any load, then bones 0, 1 and 63
		w = vertex(0);
		send(w);
		for (int r = 0; r < 3; r++) begin
			w = row_load(0, 2'(r));
			w.coef[0] = (r == 0) ? 32'sh10000 : 0;
			w.coef[1] = (r == 1) ? 32'sh10000 : 0;
			w.coef[2] = (r == 2) ? 32'sh10000 : 0;
			w.coef[3] = 0;
			send(w);
			w = row_load(63, 2'(r));
			for (int k = 0; k < 4; k++) w.coef[k] = 32'sh7FFFFFFF;
			send(w);
			w = row_load(1, 2'(r));
			for (int k = 0; k < 4; k++) w.coef[k] = 32'sh80000000;
			send(w);
		end
		// ignored row write must not disturb bone 0
		w = row_load(0, ROW_NONE);
		send(w);
		w = vertex(1);
		w.bone_set = {6'd0, 6'd0, 6'd0, 6'd0};
		w.weight_set = {4{16'hFFFF}};
		w.pos[0] = 32'sh7FFFFFFF; w.pos[1] = 32'sh80000000; w.pos[2] = 32'sh00018000;
		send(w);
		w.bone_set = {6'd1, 6'd63, 6'd1, 6'd63};
		send(w);
		w.pos[0] = 32'sh80000000; w.pos[1] = 32'sh80000000; w.pos[2] = 32'sh80000000;
		send(w);
		w.weight_set = {16'h0, 16'h8000, 16'h0, 16'h0001};
		w.bone_set = {6'd0, 6'd0, 6'd63, 6'd0};
		send(w);
		w.weight_set = '0;
		w.bone_set = 24'hFFFFFF;
		send(w);
		repeat (4) send(vertex(1));

		// random: mostly vertices over a growing palette, some loads and ignored rows
		for (int n = 0; n < 600; n++) begin
			if (n % 100 == 0) idle_on = (n % 200 != 0);
			if (n == 200) hold_cycles = 200;
			if (n == 400) begin
				@(negedge clk);
				s_tvalid <= 0;
				while (sb.expected_q.size() != 0) @(posedge clk);
				repeat (10) @(posedge clk);
			end
			if ($urandom_range(0, 9) < 3)
				w = row_load($urandom_range(0, BONES - 1),
					($urandom_range(0, 15) == 0) ? ROW_NONE : 2'($urandom_range(0, 2)));
			else
				w = vertex($urandom_range(0, 19) != 0);
			send(w);
		end
		@(negedge clk);
		s_tvalid <= 0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
